// File: hw/rtl/olfoc_pkg.sv
// Shared types, constants and the quarter-wave sine generator for the open-loop phase voltage unit.
package olfoc_pkg;

	localparam int ANGLE_BITS_DEF = 32;
	// quarter-wave depth, power of two
	localparam int SINE_DEPTH = 256;
	localparam int SIN_R_W = $clog2(SINE_DEPTH);
	localparam int SIN_N_W = SIN_R_W + 2;
	localparam int SIN_A_W = SIN_R_W + 1;
	localparam int ACC_W = 80;

	// round(2^64 / (2*pi*1e6)) split in 32-bit halves
	localparam logic [31:0] RATE_K_LO = 32'd2427840114;
	localparam logic [31:0] RATE_K_HI = 32'd683;
	localparam logic [31:0] SQRT3_Q16 = 32'd113512;

	localparam logic [1:0] CFG_SUPPLY = 2'd0;
	localparam logic [1:0] CFG_DRIVE = 2'd1;
	localparam logic [1:0] CFG_POLES = 2'd2;

	localparam logic [15:0] SUPPLY_RST = 16'd12000;
	localparam logic [15:0] DRIVE_RST = 16'd4000;
	localparam logic [6:0] POLES_RST = 7'd7;

	localparam longint Q30 = 64'sd1073741824;

	typedef enum logic [2:0] {
		MS_MD,
		MS_K00,
		MS_K01,
		MS_K10,
		MS_K11,
		MS_QS,
		MS_QC,
		MS_T
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD32,
		ACC_ADD64
	} acc_op_t;

	typedef struct packed {
		logic     load_in;
		mul_sel_t mul_sel;
		logic     st_m;
		acc_op_t  acc_op;
		logic     upd_mech;
		logic     do_elec;
		logic     do_lut;
		logic     st_a;
		logic     st_t;
		logic     do_sum;
	} olfoc_cmd_t;

	typedef struct packed {
		logic out_free;
	} olfoc_sts_t;

	typedef struct packed {
		logic [15:0] supply;
		logic [15:0] drive;
		logic [6:0]  poles;
	} olfoc_cfg_t;

	function automatic longint qmul(longint a, longint b);
		return (a * b) / Q30;
	endfunction

	// sin(pi/2 * i/SINE_DEPTH) in Q15, odd degree-9 polynomial in Q30
	function automatic logic [15:0] quarter_sine(int i);
		longint x;
		longint x2;
		longint r;
		x = (longint'(i) <<< 30) / SINE_DEPTH;
		x2 = qmul(x, x);
		r = 172272;
		r = -5026995 + qmul(r, x2);
		r = 85569306 + qmul(r, x2);
		r = -693598668 + qmul(r, x2);
		r = 1686629713 + qmul(r, x2);
		r = qmul(r, x);
		if (r < 0) begin
			r = 0;
		end
		return 16'((r + 16384) >>> 15);
	endfunction

endpackage

// File: hw/rtl/olfoc_ctrl.sv
// Sequencer for the open-loop phase voltage unit: steps the datapath through one word.
module olfoc_ctrl
	import olfoc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  olfoc_sts_t sts,
	output olfoc_cmd_t cmd
);

	typedef enum logic [14:0] {
		ST_IDLE = 15'b000000000000001,
		ST_MD   = 15'b000000000000010,
		ST_K00  = 15'b000000000000100,
		ST_K01  = 15'b000000000001000,
		ST_K10  = 15'b000000000010000,
		ST_K11  = 15'b000000000100000,
		ST_ACC  = 15'b000000001000000,
		ST_UPD  = 15'b000000010000000,
		ST_ELEC = 15'b000000100000000,
		ST_LUT  = 15'b000001000000000,
		ST_QS   = 15'b000010000000000,
		ST_QC   = 15'b000100000000000,
		ST_TM   = 15'b001000000000000,
		ST_ST   = 15'b010000000000000,
		ST_SUM  = 15'b100000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.mul_sel = MS_MD;
		cmd.acc_op = ACC_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = ST_MD;
				end
			end
			ST_MD: begin
				cmd.mul_sel = MS_MD;
				state_d = ST_K00;
			end
			ST_K00: begin
				cmd.mul_sel = MS_K00;
				cmd.st_m = 1'b1;
				state_d = ST_K01;
			end
			ST_K01: begin
				cmd.mul_sel = MS_K01;
				cmd.acc_op = ACC_LOAD;
				state_d = ST_K10;
			end
			ST_K10: begin
				cmd.mul_sel = MS_K10;
				cmd.acc_op = ACC_ADD32;
				state_d = ST_K11;
			end
			ST_K11: begin
				cmd.mul_sel = MS_K11;
				cmd.acc_op = ACC_ADD32;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_op = ACC_ADD64;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd_mech = 1'b1;
				state_d = ST_ELEC;
			end
			ST_ELEC: begin
				cmd.do_elec = 1'b1;
				state_d = ST_LUT;
			end
			ST_LUT: begin
				cmd.do_lut = 1'b1;
				state_d = ST_QS;
			end
			ST_QS: begin
				cmd.mul_sel = MS_QS;
				state_d = ST_QC;
			end
			ST_QC: begin
				cmd.mul_sel = MS_QC;
				cmd.st_a = 1'b1;
				state_d = ST_TM;
			end
			ST_TM: begin
				cmd.mul_sel = MS_T;
				state_d = ST_ST;
			end
			ST_ST: begin
				cmd.st_t = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				if (sts.out_free) begin
					cmd.do_sum = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/olfoc_dp.sv
// Datapath of the open-loop phase voltage unit: angle integrator, sine table, transforms, output word.
module olfoc_dp
	import olfoc_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  olfoc_cmd_t  cmd,
	output olfoc_sts_t  sts,
	input  olfoc_cfg_t  cfg,
	input  logic [31:0] in_stamp,
	input  logic [31:0] in_speed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_data
);

	logic [31:0] prev_time_q;
	logic [31:0] dt_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [63:0] prod_q;
	logic [63:0] m_q;
	logic [ACC_W-1:0] acc_q;
	logic [ANGLE_BITS-1:0] inc;
	logic [ANGLE_BITS-1:0] mech_q;
	logic [ANGLE_BITS-1:0] elec_q;
	logic [15:0] s_mag_q;
	logic [15:0] c_mag_q;
	logic        s_neg_q;
	logic        c_neg_q;
	logic signed [35:0] a_q;
	logic signed [35:0] t_q;
	logic [15:0] held_u_q;
	logic [15:0] held_v_q;
	logic [15:0] held_w_q;
	logic [15:0] angle_q;
	logic        out_valid_q;

	logic [15:0] sine_rom [SINE_DEPTH+1];
	logic [SIN_N_W-1:0] n_idx;
	logic [1:0] s_quad;
	logic [1:0] c_quad;
	logic [SIN_R_W-1:0] r_idx;
	logic [SIN_A_W-1:0] s_addr;
	logic [SIN_A_W-1:0] c_addr;

	logic signed [35:0] h;
	logic signed [35:0] dv;
	logic signed [35:0] dw;
	logic signed [35:0] x_u;
	logic signed [35:0] x_v;
	logic signed [35:0] x_w;

	function automatic logic [15:0] phase_pick(logic signed [35:0] x, logic [15:0] supply,
		logic [15:0] held);
		logic signed [35:0] top;
		logic [35:0] rnd;
		top = $signed({5'b0, supply, 15'b0});
		rnd = x + 36'sd16384;
		if (x < 0 || x > top) begin
			return held;
		end
		return rnd[30:15];
	endfunction

	for (genvar gi = 0; gi <= SINE_DEPTH; gi++) begin : g_rom
		assign sine_rom[gi] = quarter_sine(gi);
	end

	// shared 32x32 multiplier
	always_comb begin
		case (cmd.mul_sel)
			MS_MD: begin
				mul_a = mag_q;
				mul_b = dt_q;
			end
			MS_K00: begin
				mul_a = prod_q[31:0];
				mul_b = RATE_K_LO;
			end
			MS_K01: begin
				mul_a = m_q[31:0];
				mul_b = RATE_K_HI;
			end
			MS_K10: begin
				mul_a = m_q[63:32];
				mul_b = RATE_K_LO;
			end
			MS_K11: begin
				mul_a = m_q[63:32];
				mul_b = RATE_K_HI;
			end
			MS_QS: begin
				mul_a = {16'b0, cfg.drive};
				mul_b = {16'b0, s_mag_q};
			end
			MS_QC: begin
				mul_a = {16'b0, cfg.drive};
				mul_b = {16'b0, c_mag_q};
			end
			MS_T: begin
				mul_a = prod_q[31:0];
				mul_b = SQRT3_Q16;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign inc = acc_q[ACC_W-ANGLE_BITS +: ANGLE_BITS];

	// table addressing
	assign n_idx = elec_q[ANGLE_BITS-1 -: SIN_N_W];
	assign s_quad = n_idx[SIN_N_W-1 -: 2];
	assign c_quad = s_quad + 2'd1;
	assign r_idx = n_idx[SIN_R_W-1:0];
	assign s_addr = s_quad[0] ? SIN_A_W'(SINE_DEPTH) - {1'b0, r_idx} : {1'b0, r_idx};
	assign c_addr = c_quad[0] ? SIN_A_W'(SINE_DEPTH) - {1'b0, r_idx} : {1'b0, r_idx};

	// inverse Park / Clarke with half-supply offset, halves truncate toward zero
	always_comb begin
		h = $signed({6'b0, cfg.supply, 14'b0});
		dv = t_q - a_q;
		dw = -t_q - a_q;
		x_u = a_q + h;
		x_v = ((dv + $signed({35'b0, dv[35]})) >>> 1) + h;
		x_w = ((dw + $signed({35'b0, dw[35]})) >>> 1) + h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
			mech_q <= '0;
			held_u_q <= '0;
			held_v_q <= '0;
			held_w_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				prev_time_q <= in_stamp;
			end
			if (cmd.upd_mech) begin
				mech_q <= neg_q ? mech_q - inc : mech_q + inc;
			end
			if (cmd.do_sum) begin
				held_u_q <= phase_pick(x_u, cfg.supply, held_u_q);
				held_v_q <= phase_pick(x_v, cfg.supply, held_v_q);
				held_w_q <= phase_pick(x_w, cfg.supply, held_w_q);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (cmd.load_in) begin
			dt_q <= in_stamp - prev_time_q;
			neg_q <= in_speed[31];
			mag_q <= in_speed[31] ? (~in_speed + 32'd1) : in_speed;
		end
		if (cmd.st_m) begin
			m_q <= prod_q;
		end
		case (cmd.acc_op)
			ACC_LOAD:  acc_q <= ACC_W'(prod_q);
			ACC_ADD32: acc_q <= acc_q + (ACC_W'(prod_q) << 32);
			ACC_ADD64: acc_q <= acc_q + (ACC_W'(prod_q) << 64);
			default:   acc_q <= acc_q;
		endcase
		if (cmd.do_elec) begin
			elec_q <= ANGLE_BITS'(mech_q * cfg.poles);
		end
		if (cmd.do_lut) begin
			s_mag_q <= sine_rom[s_addr];
			c_mag_q <= sine_rom[c_addr];
			s_neg_q <= s_quad[1];
			c_neg_q <= c_quad[1];
		end
		if (cmd.st_a) begin
			a_q <= s_neg_q ? $signed({4'b0, prod_q[31:0]}) : -$signed({4'b0, prod_q[31:0]});
		end
		if (cmd.st_t) begin
			t_q <= c_neg_q ? -$signed({4'b0, prod_q[47:16]}) : $signed({4'b0, prod_q[47:16]});
		end
		if (cmd.do_sum) begin
			angle_q <= elec_q[ANGLE_BITS-1 -: 16];
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = {angle_q, held_w_q, held_v_q, held_u_q};

endmodule

// File: hw/rtl/open_loop_foc_phase_voltage_unit.sv
// Top level of the open-loop phase voltage unit: configuration registers, sequencer and datapath.
//
// Each input word (timestamp in microseconds, signed Q16.16 speed in rad/s) advances a wrapping
// mechanical angle by speed times elapsed time, scales it by the pole pairs to an electrical angle,
// and produces three phase voltages in millivolts through inverse Park and Clarke transforms with
// the q drive voltage, offset by half the supply; a phase outside 0..supply keeps its last value.
// One word is processed at a time: the result register is loaded in the last sequencer state,
// after the multiply, angle, table and transform states, and the next word can be taken in the
// following cycle. The single shared 32x32 multiplier does the eight products in turn. The result
// register lets the next word be accepted while the previous result waits; a word finishing while
// the previous result is still held stalls until it is taken. Configuration writes are always
// taken (cfg_ready high) and must only be issued while the unit is idle.
module open_loop_foc_phase_voltage_unit
	import olfoc_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // time_stamp[31:0], target_speed[63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // phase_u, phase_v, phase_w, electric_angle (16b each)
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	olfoc_cfg_t cfg_q;
	olfoc_cmd_t cmd;
	olfoc_sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.supply <= SUPPLY_RST;
			cfg_q.drive <= DRIVE_RST;
			cfg_q.poles <= POLES_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SUPPLY: cfg_q.supply <= cfg_data;
				CFG_DRIVE:  cfg_q.drive <= cfg_data;
				CFG_POLES:  cfg_q.poles <= cfg_data[6:0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	olfoc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	olfoc_dp #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg       (cfg_q),
		.in_stamp  (s_tdata[31:0]),
		.in_speed  (s_tdata[63:32]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a word is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_sum |-> (!m_tvalid || m_tready))
		else $error("result register overwritten before it was taken");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_sum |=> m_tvalid)
		else $error("finished word not presented on the output");

endmodule
